// ===== hdl/biou_pkg.sv =====
package biou_pkg;

    localparam int COORD_W = 17;   // signed Q12.4 corner
    localparam int EXT_W   = 17;   // clamped overlap extent, unsigned Q.4
    localparam int AREA_W  = 32;   // unsigned Q24.8 area
    localparam int SUM_W   = 33;   // a_area + b_area
    localparam int INTER_W = 34;   // w * h, unsigned Q.8
    localparam int UNI_W   = 35;   // signed union
    localparam int REM_W   = 33;   // divider remainder, below the divisor whenever the quotient is used
    localparam int QUOT_W  = 16;   // quotient bits when the ratio is below one
    localparam int RATIO_W = 17;   // Q0.16 with room for 1.0

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

    typedef struct packed {
        logic valid;
        logic undef;   // union zero or negative
        logic sat;     // intersection >= union, ratio clips at 1.0
    } t_div_ctl;

endpackage

// ===== hdl/biou_overlap.sv =====
module biou_overlap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_top,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_right,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_bottom,
    input  logic        [biou_pkg::AREA_W-1:0]  i_a_area,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_top,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_right,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_bottom,
    input  logic        [biou_pkg::AREA_W-1:0]  i_b_area,
    output logic                                o_valid,
    output logic        [biou_pkg::INTER_W-1:0] o_inter,
    output logic        [biou_pkg::SUM_W-1:0]   o_area_sum
);
    import biou_pkg::*;

    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_W:0]   dx, dy;
    logic        [EXT_W-1:0]   n_w, n_h;
    logic        [SUM_W-1:0]   n_sum;

    logic                 r_v1, r_v2;
    logic [EXT_W-1:0]     r_w, r_h;
    logic [SUM_W-1:0]     r_sum1, r_sum2;
    logic [INTER_W-1:0]   r_inter;

    always_comb begin
        lo_x = (i_a_left > i_b_left) ? i_a_left : i_b_left;
        hi_x = (i_a_right < i_b_right) ? i_a_right : i_b_right;
        lo_y = (i_a_top > i_b_top) ? i_a_top : i_b_top;
        hi_y = (i_a_bottom < i_b_bottom) ? i_a_bottom : i_b_bottom;
        dx   = {hi_x[COORD_W-1], hi_x} - {lo_x[COORD_W-1], lo_x};
        dy   = {hi_y[COORD_W-1], hi_y} - {lo_y[COORD_W-1], lo_y};
        // negative extent clamps to zero; positive extent fits in 17 bits
        n_w  = dx[COORD_W] ? '0 : dx[EXT_W-1:0];
        n_h  = dy[COORD_W] ? '0 : dy[EXT_W-1:0];
        n_sum = SUM_W'(i_a_area) + SUM_W'(i_b_area);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_w     <= n_w;
        r_h     <= n_h;
        r_sum1  <= n_sum;
        r_inter <= INTER_W'(r_w) * INTER_W'(r_h);
        r_sum2  <= r_sum1;
    end

    assign o_valid    = r_v2;
    assign o_inter    = r_inter;
    assign o_area_sum = r_sum2;

endmodule

// ===== hdl/biou_union.sv =====
module biou_union (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [biou_pkg::INTER_W-1:0]        i_inter,
    input  logic [biou_pkg::SUM_W-1:0]          i_area_sum,
    output biou_pkg::t_div_ctl                  o_ctl,
    output logic [biou_pkg::REM_W-1:0]          o_rem,
    output logic [biou_pkg::REM_W-1:0]          o_div
);
    import biou_pkg::*;

    logic               r_v3;
    logic [UNI_W-1:0]   r_uni;
    logic [INTER_W-1:0] r_inter3;

    t_div_ctl           r_ctl;
    t_div_ctl           n_ctl;
    logic [REM_W-1:0]   r_rem, r_div;

    always_comb begin
        n_ctl.valid = r_v3;
        n_ctl.undef = r_uni[UNI_W-1] || (r_uni == '0);
        n_ctl.sat   = !n_ctl.undef && (r_inter3 >= r_uni[INTER_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_ctl.valid <= 1'b0;
        end else begin
            r_v3  <= i_valid;
            r_ctl <= n_ctl;
        end
        r_uni    <= {2'b00, i_area_sum} - {1'b0, i_inter};
        r_inter3 <= i_inter;
        // below the union whenever the divider result is used
        r_rem    <= r_inter3[REM_W-1:0];
        r_div    <= r_uni[REM_W-1:0];
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_div = r_div;

endmodule

// ===== hdl/biou_div_stage.sv =====
module biou_div_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  biou_pkg::t_div_ctl            i_ctl,
    input  logic [biou_pkg::REM_W-1:0]    i_rem,
    input  logic [biou_pkg::REM_W-1:0]    i_div,
    input  logic [biou_pkg::QUOT_W-1:0]   i_quot,
    output biou_pkg::t_div_ctl            o_ctl,
    output logic [biou_pkg::REM_W-1:0]    o_rem,
    output logic [biou_pkg::REM_W-1:0]    o_div,
    output logic [biou_pkg::QUOT_W-1:0]   o_quot
);
    import biou_pkg::*;

    logic [REM_W:0]    shifted, diff;
    logic              ge;
    logic [REM_W-1:0]  n_rem;

    t_div_ctl          r_ctl;
    logic [REM_W-1:0]  r_rem, r_div;
    logic [QUOT_W-1:0] r_quot;

    // one restoring step: remainder stays below the divisor
    always_comb begin
        shifted = {i_rem, 1'b0};
        diff    = shifted - {1'b0, i_div};
        ge      = shifted >= {1'b0, i_div};
        n_rem   = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem  <= n_rem;
        r_div  <= i_div;
        r_quot <= {i_quot[QUOT_W-2:0], ge};
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_div  = r_div;
    assign o_quot = r_quot;

endmodule

// ===== hdl/box_intersection_over_union.sv =====
// Pipeline: four front stages (overlap, multiply, union, flags), 16 quotient stages
// of one bit each, then the output register.
// Throughput: one beat per cycle; busy stays low and the result strobe cannot be held off.
// Reset: synchronous, active low; clears the valid bits of every stage, so no
// strobe follows reset until a new beat is accepted.
module box_intersection_over_union (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_top,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_right,
    input  logic signed [biou_pkg::COORD_W-1:0] i_a_bottom,
    input  logic        [biou_pkg::AREA_W-1:0]  i_a_area,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_top,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_right,
    input  logic signed [biou_pkg::COORD_W-1:0] i_b_bottom,
    input  logic        [biou_pkg::AREA_W-1:0]  i_b_area,
    output logic                                o_strobe,
    output logic        [biou_pkg::RATIO_W-1:0] o_overlap_ratio,
    output logic                                o_ratio_undefined
);
    import biou_pkg::*;

    logic               ov_valid;
    logic [INTER_W-1:0] ov_inter;
    logic [SUM_W-1:0]   ov_sum;

    t_div_ctl           s_ctl  [0:QUOT_W];
    logic [REM_W-1:0]   s_rem  [0:QUOT_W];
    logic [REM_W-1:0]   s_div  [0:QUOT_W];
    logic [QUOT_W-1:0]  s_quot [0:QUOT_W];

    logic               r_strobe;
    logic [RATIO_W-1:0] r_ratio;
    logic               r_undef;
    logic [RATIO_W-1:0] n_ratio;

    assign busy = 1'b0;

    biou_overlap u_overlap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_right  (i_a_right),
        .i_a_bottom (i_a_bottom),
        .i_a_area   (i_a_area),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_right  (i_b_right),
        .i_b_bottom (i_b_bottom),
        .i_b_area   (i_b_area),
        .o_valid    (ov_valid),
        .o_inter    (ov_inter),
        .o_area_sum (ov_sum)
    );

    biou_union u_union (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (ov_valid),
        .i_inter    (ov_inter),
        .i_area_sum (ov_sum),
        .o_ctl      (s_ctl[0]),
        .o_rem      (s_rem[0]),
        .o_div      (s_div[0])
    );

    assign s_quot[0] = '0;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        biou_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_div   (s_div[k]),
            .i_quot  (s_quot[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_div   (s_div[k+1]),
            .o_quot  (s_quot[k+1])
        );
    end

    always_comb begin
        priority if (s_ctl[QUOT_W].undef) begin
            n_ratio = '0;
        end else if (s_ctl[QUOT_W].sat) begin
            n_ratio = RATIO_ONE;
        end else begin
            n_ratio = {1'b0, s_quot[QUOT_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_ctl[QUOT_W].valid;
        end
        r_ratio <= n_ratio;
        r_undef <= s_ctl[QUOT_W].undef;
    end

    assign o_strobe          = r_strobe;
    assign o_overlap_ratio   = r_ratio;
    assign o_ratio_undefined = r_undef;

endmodule
